FILE: design/transpose_address_generator_3d_core_assert.svh
// Assertion macros for the transpose address generator.
`ifndef TRANSPOSE_ADDRESS_GENERATOR_3D_CORE_ASSERT_SVH
`define TRANSPOSE_ADDRESS_GENERATOR_3D_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define TAG3D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define TAG3D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tag3d_pkg.sv
// Constants, types and helpers for the transpose address generator.
`default_nettype none

package tag3d_pkg;

  localparam int MaxExtent = 1024;

  // Extent registers hold 0..MaxExtent, positions 0..MaxExtent-1.
  localparam int ExtW    = $clog2(MaxExtent + 1);
  localparam int PosW    = (MaxExtent > 1) ? $clog2(MaxExtent) : 1;
  localparam int StrideW = 2 * ExtW - 1;
  localparam int AxisW   = 2;
  localparam int OffW    = 30;

  localparam int PrW   = PosW + StrideW;
  localparam int SumW  = (PrW + 2 > OffW) ? PrW + 2 : OffW;
  localparam int DmW   = PosW + ExtW + 1;
  localparam int DstW  = (DmW + ExtW + 1 > OffW) ? DmW + ExtW + 1 : OffW;
  localparam int OutW  = ((2 * OffW + 7) / 8) * 8;
  localparam int InW   = 8;
  localparam int CfgIdxW = 3;

  typedef logic [ExtW-1:0]    ext_t;
  typedef logic [PosW-1:0]    pos_t;
  typedef logic [StrideW-1:0] stride_t;
  typedef logic [AxisW-1:0]   axis_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegExtent0     = 3'd0,
    RegExtent1     = 3'd1,
    RegExtent2     = 3'd2,
    RegAxisOuter   = 3'd3,
    RegAxisMiddle  = 3'd4,
    RegAxisInner   = 3'd5
  } cfg_reg_e;

  localparam axis_t AxisOuter  = 2'd0;
  localparam axis_t AxisMiddle = 2'd1;
  localparam axis_t AxisInner  = 2'd2;

  function automatic ext_t clamp_extent(input ext_t v);
    clamp_extent = (v > ext_t'(MaxExtent)) ? ext_t'(MaxExtent) : v;
  endfunction

  // Selector code 3 behaves as the innermost axis.
  function automatic axis_t clamp_axis(input axis_t v);
    clamp_axis = (v > AxisInner) ? AxisInner : v;
  endfunction

endpackage

`default_nettype wire

FILE: design/transpose_address_generator_3d_core.sv
// Three-axis transpose address generator: position walk and offset pipeline.
//
//  channel  dir  handshake              payload
//  -------  ---  ---------------------  -----------------------------------------
//  s_axis   in   tvalid/tready          tdata[0] restart
//  m_axis   out  tvalid/tready          tdata source/dest offset, tlast end of pass
//  cfg      in   cfg_we_i (no wait)     cfg_index_i, cfg_wdata_i
//
// One input transfer per cycle, sustained while m_axis takes results. A result
// passes through the stages in order: position walk into stage A, products in
// stage B, the last destination product and the final adds in stage C (the
// output register). Each stage has its own valid bit and loads when it is empty
// or its contents move on, so bubbles are squeezed out; while a result waits on
// m_axis, two more transfers that yield results are still taken before s_axis
// stalls. Reset clears the valid bits, the pass state and the configuration to
// its reset values.
`default_nettype none
`include "transpose_address_generator_3d_core_assert.svh"

module transpose_address_generator_3d_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [tag3d_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [tag3d_pkg::ExtW-1:0]     cfg_wdata_i,
  // input stream
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [tag3d_pkg::InW-1:0]      s_axis_tdata_i,   // [0] restart
  // result stream
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [tag3d_pkg::OutW-1:0]          m_axis_tdata_o,   // [29:0] source_offset,
                                                                // [59:30] dest_offset
  output logic                                m_axis_tlast_o    // last
);

  import tag3d_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration and derived outer stride
  // ---------------------------------------------------------------------------
  ext_t    ext_q [3];
  axis_t   axis_q [3];
  stride_t stride0_q;      // extent_1 * extent_2; the middle stride is extent_2

  ext_t cfg_ext;
  assign cfg_ext = clamp_extent(cfg_wdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q[0]  <= ext_t'(1);
      ext_q[1]  <= ext_t'(1);
      ext_q[2]  <= ext_t'(1);
      axis_q[0] <= AxisOuter;
      axis_q[1] <= AxisMiddle;
      axis_q[2] <= AxisInner;
      stride0_q <= stride_t'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegExtent0: ext_q[0] <= cfg_ext;
        RegExtent1: begin
          ext_q[1]  <= cfg_ext;
          stride0_q <= stride_t'(cfg_ext) * stride_t'(ext_q[2]);
        end
        RegExtent2: begin
          ext_q[2]  <= cfg_ext;
          stride0_q <= stride_t'(ext_q[1]) * stride_t'(cfg_ext);
        end
        RegAxisOuter:  axis_q[0] <= clamp_axis(cfg_wdata_i[AxisW-1:0]);
        RegAxisMiddle: axis_q[1] <= clamp_axis(cfg_wdata_i[AxisW-1:0]);
        RegAxisInner:  axis_q[2] <= clamp_axis(cfg_wdata_i[AxisW-1:0]);
        default: ;   // indexes past the register list are dropped
      endcase
    end
  end

  // Transposed extents and the source stride of each output axis.
  ext_t    te [3];
  stride_t st [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (axis_q[k])
        AxisOuter: begin
          te[k] = ext_q[0];
          st[k] = stride0_q;
        end
        AxisMiddle: begin
          te[k] = ext_q[1];
          st[k] = stride_t'(ext_q[2]);
        end
        default: begin
          te[k] = ext_q[2];
          st[k] = stride_t'(1);
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage handshake
  // ---------------------------------------------------------------------------
  logic va_q, vb_q, vc_q;
  logic rdy_a, rdy_b, rdy_c;
  logic s_fire;

  assign rdy_c = !vc_q || m_axis_tready_i;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;

  assign s_axis_tready_o = rdy_a;
  assign s_fire          = s_axis_tvalid_i && rdy_a;

  // ---------------------------------------------------------------------------
  // Position walk (row-major over the transposed extents)
  // ---------------------------------------------------------------------------
  pos_t pos_outer_q, pos_middle_q, pos_inner_q;
  logic pass_active_q;

  pos_t pos_outer_d, pos_middle_d, pos_inner_d;
  logic pass_active_d;
  logic res_valid, res_last;
  logic restart, any_zero;
  ext_t inc_outer, inc_middle, inc_inner;

  assign restart  = s_axis_tdata_i[0];
  assign any_zero = (te[0] == '0) || (te[1] == '0) || (te[2] == '0);

  always_comb begin
    pos_outer_d   = pos_outer_q;
    pos_middle_d  = pos_middle_q;
    pos_inner_d   = pos_inner_q;
    pass_active_d = pass_active_q;
    res_valid     = 1'b0;

    inc_inner  = ext_t'(pos_inner_q) + ext_t'(1);
    inc_middle = ext_t'(pos_middle_q) + ext_t'(1);
    inc_outer  = ext_t'(pos_outer_q) + ext_t'(1);

    if (restart) begin
      pos_outer_d   = '0;
      pos_middle_d  = '0;
      pos_inner_d   = '0;
      pass_active_d = 1'b0;
      res_valid     = !any_zero;
    end else if (pass_active_q) begin
      if (any_zero) begin
        pass_active_d = 1'b0;
      end else begin
        res_valid = 1'b1;
        // counters carry whenever their next value reaches or passes their extent
        if (inc_inner >= te[2]) begin
          pos_inner_d = '0;
          if (inc_middle >= te[1]) begin
            pos_middle_d = '0;
            if (inc_outer >= te[0]) begin
              pos_outer_d   = '0;
              pass_active_d = 1'b0;
              res_valid     = 1'b0;
            end else begin
              pos_outer_d = inc_outer[PosW-1:0];
            end
          end else begin
            pos_middle_d = inc_middle[PosW-1:0];
          end
        end else begin
          pos_inner_d = inc_inner[PosW-1:0];
        end
      end
    end

    res_last = ((ext_t'(pos_outer_d) + ext_t'(1)) >= te[0])
            && ((ext_t'(pos_middle_d) + ext_t'(1)) >= te[1])
            && ((ext_t'(pos_inner_d) + ext_t'(1)) >= te[2]);
    if (res_valid) begin
      pass_active_d = !res_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_outer_q   <= '0;
      pos_middle_q  <= '0;
      pos_inner_q   <= '0;
      pass_active_q <= 1'b0;
    end else if (s_fire) begin
      pos_outer_q   <= pos_outer_d;
      pos_middle_q  <= pos_middle_d;
      pos_inner_q   <= pos_inner_d;
      pass_active_q <= pass_active_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: position snapshot with the configuration it was taken under
  // ---------------------------------------------------------------------------
  pos_t    a_po_q, a_pm_q, a_pi_q;
  stride_t a_s0_q, a_s1_q, a_s2_q;
  ext_t    a_te1_q, a_te2_q;
  logic    a_last_q;

  always_ff @(posedge clk_i) begin
    if (s_fire && res_valid) begin
      a_po_q   <= pos_outer_d;
      a_pm_q   <= pos_middle_d;
      a_pi_q   <= pos_inner_d;
      a_s0_q   <= st[0];
      a_s1_q   <= st[1];
      a_s2_q   <= st[2];
      a_te1_q  <= te[1];
      a_te2_q  <= te[2];
      a_last_q <= res_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: stride products and the first half of the destination offset
  // ---------------------------------------------------------------------------
  logic [PrW-1:0] b_p0_q, b_p1_q, b_p2_q;
  logic [DmW-1:0] b_dm_q;
  pos_t           b_pi_q;
  ext_t           b_te2_q;
  logic           b_last_q;

  always_ff @(posedge clk_i) begin
    if (rdy_b && va_q) begin
      b_p0_q   <= PrW'(a_po_q) * PrW'(a_s0_q);
      b_p1_q   <= PrW'(a_pm_q) * PrW'(a_s1_q);
      b_p2_q   <= PrW'(a_pi_q) * PrW'(a_s2_q);
      b_dm_q   <= DmW'(a_po_q) * DmW'(a_te1_q) + DmW'(a_pm_q);
      b_pi_q   <= a_pi_q;
      b_te2_q  <= a_te2_q;
      b_last_q <= a_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: output register
  // ---------------------------------------------------------------------------
  logic [SumW-1:0] src_sum;
  logic [DstW-1:0] dst_sum;
  logic [OffW-1:0] c_src_q, c_dst_q;
  logic            c_last_q;

  assign src_sum = SumW'(b_p0_q) + SumW'(b_p1_q) + SumW'(b_p2_q);
  assign dst_sum = DstW'(b_dm_q) * DstW'(b_te2_q) + DstW'(b_pi_q);

  always_ff @(posedge clk_i) begin
    if (rdy_c && vb_q) begin
      c_src_q  <= src_sum[OffW-1:0];
      c_dst_q  <= dst_sum[OffW-1:0];
      c_last_q <= b_last_q;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= s_fire && res_valid;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  assign m_axis_tvalid_o = vc_q;
  assign m_axis_tdata_o  = {{(OutW - 2 * OffW){1'b0}}, c_dst_q, c_src_q};
  assign m_axis_tlast_o  = c_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TAG3D_ASSERT_NXT(a_restart_emits, s_fire && restart && !any_zero, va_q,
    "restart over nonempty extents gave no origin result")
  `TAG3D_ASSERT_NXT(a_idle_advance_silent, s_fire && !restart && !pass_active_q, !va_q,
    "advance with no pass running produced a result")
  `TAG3D_ASSERT_NXT(a_last_ends_pass, s_fire && res_valid && res_last, !pass_active_q,
    "pass still running after its last address pair")
  `TAG3D_ASSERT_IMP(a_stall_only_when_full, !s_axis_tready_o, va_q && vb_q && vc_q,
    "input stalled while a pipeline stage is empty")

endmodule

`default_nettype wire
